/* src/max_pool_2x2_stream_core_macros.svh */
// Assertion macros for the 2x2 max pooling core.
// Define ASSERT_OFF to compile the checks out.
`ifndef MAX_POOL_2X2_STREAM_CORE_MACROS_SVH
`define MAX_POOL_2X2_STREAM_CORE_MACROS_SVH

`ifndef ASSERT_OFF
`define MP2X2_ASSERT(label, clk, rst, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("mp2x2: invariant violated");
`define MP2X2_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("mp2x2: sequence check failed");
`else
`define MP2X2_ASSERT(label, clk, rst, cond)
`define MP2X2_ASSERT_NXT(label, clk, rst, ante, cons)
`endif

`endif

/* src/mp2x2_pkg.sv */
// Shared types, constants and helpers for the 2x2 max pooling core.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package mp2x2_pkg;

  localparam int PIX_W       = 8;
  localparam int CFG_W       = 11;
  localparam int CFG_INDEX_W = 2;

  localparam int DEF_MAX_WIDTH  = 1024;
  localparam int DEF_MAX_HEIGHT = 1024;

  localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;

  // window waiting for its store read to return
  typedef struct packed {
    logic                    valid;
    logic signed [PIX_W-1:0] pair;
    logic                    last;
  } win_t;

  function automatic logic signed [PIX_W-1:0] max_s8(
    input logic signed [PIX_W-1:0] a,
    input logic signed [PIX_W-1:0] b
  );
    max_s8 = (b > a) ? b : a;
  endfunction

endpackage

`default_nettype wire

/* src/mp2x2_ram.sv */
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module mp2x2_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 512,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

/* src/mp2x2_cfg.sv */
// Geometry registers: image width and height, clamped on write.
// Depends on mp2x2_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mp2x2_cfg #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024,
  parameter int DW         = $clog2(MAX_WIDTH + 1),
  parameter int DH         = $clog2(MAX_HEIGHT + 1)
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                cfg_valid,
  output logic                                     cfg_ready,
  input  wire logic [mp2x2_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  wire logic [mp2x2_pkg::CFG_W-1:0]         cfg_data,
  output logic      [DW-1:0]                       width_eff,
  output logic      [DH-1:0]                       height_eff
);
  import mp2x2_pkg::*;

  localparam int CW_W = (DW > CFG_W) ? DW : CFG_W;
  localparam int CW_H = (DH > CFG_W) ? DH : CFG_W;

  logic [CW_W-1:0] data_w;
  logic [CW_H-1:0] data_h;
  logic [DW-1:0]   width_next;
  logic [DH-1:0]   height_next;

  assign cfg_ready = 1'b1;
  assign data_w    = CW_W'(cfg_data);
  assign data_h    = CW_H'(cfg_data);

  always_comb begin
    if (data_w < CW_W'(2)) begin
      width_next = DW'(2);
    end else if (data_w > CW_W'(MAX_WIDTH)) begin
      width_next = DW'(MAX_WIDTH);
    end else begin
      width_next = DW'(data_w);
    end
    if (data_h < CW_H'(2)) begin
      height_next = DH'(2);
    end else if (data_h > CW_H'(MAX_HEIGHT)) begin
      height_next = DH'(MAX_HEIGHT);
    end else begin
      height_next = DH'(data_h);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      width_eff  <= DW'(2);
      height_eff <= DH'(2);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_IMAGE_WIDTH:  width_eff  <= width_next;
        REG_IMAGE_HEIGHT: height_eff <= height_next;
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

/* src/mp2x2_ctrl.sv */
// Raster counters, held pixel and line store access for the pooling core.
// Depends on mp2x2_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "max_pool_2x2_stream_core_macros.svh"
`default_nettype none

module mp2x2_ctrl #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024,
  parameter int DW         = $clog2(MAX_WIDTH + 1),
  parameter int DH         = $clog2(MAX_HEIGHT + 1),
  parameter int CW         = $clog2(MAX_WIDTH),
  parameter int RW         = $clog2(MAX_HEIGHT),
  parameter int AW         = (MAX_WIDTH / 2 > 1) ? $clog2(MAX_WIDTH / 2) : 1
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic [DW-1:0]                        width_eff,
  input  wire logic [DH-1:0]                        height_eff,
  input  wire logic                                 pixel_valid,
  output logic                                      pixel_stall,
  input  wire logic signed [mp2x2_pkg::PIX_W-1:0]   pixel_value,
  input  wire logic                                 out_ready,
  output mp2x2_pkg::win_t                           win,
  output logic                                      mem_we,
  output logic      [AW-1:0]                        mem_waddr,
  output logic      [mp2x2_pkg::PIX_W-1:0]          mem_wdata,
  output logic                                      mem_re,
  output logic      [AW-1:0]                        mem_raddr
);
  import mp2x2_pkg::*;

  logic [CW-1:0]           column_count;
  logic [RW-1:0]           row_count;
  logic signed [PIX_W-1:0] held_pixel;

  logic                    accept;
  logic [DW-1:0]           pooled_w;
  logic [DH-1:0]           pooled_h;
  logic [DW-1:0]           col_ext;
  logic [DH-1:0]           row_ext;
  logic [DW-1:0]           col_inc;
  logic [DH-1:0]           row_inc;
  logic                    in_window;
  logic                    emit;
  logic signed [PIX_W-1:0] pair_max;
  logic [AW-1:0]           slot;

  // a waiting window blocks intake only when the output cannot move
  assign pixel_stall = win.valid && !out_ready;
  assign accept      = pixel_valid && !pixel_stall;

  assign pooled_w  = width_eff & ~DW'(1);
  assign pooled_h  = height_eff & ~DH'(1);
  assign col_ext   = DW'(column_count);
  assign row_ext   = DH'(row_count);
  assign col_inc   = col_ext + DW'(1);
  assign row_inc   = row_ext + DH'(1);
  assign in_window = (col_ext < pooled_w) && (row_ext < pooled_h);
  assign pair_max  = max_s8(held_pixel, pixel_value);
  assign slot      = AW'(column_count >> 1);

  // even row, odd column: write pair max; odd row, odd column: fetch it
  assign emit      = accept && in_window && column_count[0] && row_count[0];
  assign mem_we    = accept && in_window && column_count[0] && !row_count[0];
  assign mem_re    = emit;
  assign mem_waddr = slot;
  assign mem_raddr = slot;
  assign mem_wdata = pair_max;

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
      held_pixel   <= '0;
    end else if (accept) begin
      if (in_window && !column_count[0]) begin
        held_pixel <= pixel_value;
      end
      if (col_inc >= width_eff) begin
        column_count <= '0;
        if (row_inc >= height_eff) begin
          row_count <= '0;
        end else begin
          row_count <= RW'(row_inc);
        end
      end else begin
        column_count <= CW'(col_inc);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      win.valid <= 1'b0;
    end else if (accept) begin
      win.valid <= emit;
    end else if (out_ready) begin
      win.valid <= 1'b0;
    end
    if (emit) begin
      win.pair <= pair_max;
      win.last <= (col_ext == pooled_w - DW'(1)) && (row_ext == pooled_h - DH'(1));
    end
  end

  // Store write and read come from different rows, so they never meet on one entry
  // inside a cycle or in back-to-back cycles; no forwarding path is needed.
  `MP2X2_ASSERT(a_no_rw_same_cycle, clk, rst, !(mem_we && mem_re))
  `MP2X2_ASSERT_NXT(a_no_raw_next, clk, rst, mem_we,
                    !(mem_re && (mem_raddr == $past(mem_waddr))))
  `MP2X2_ASSERT_NXT(a_win_held, clk, rst, win.valid && !out_ready,
                    win.valid && $stable(win.pair) && $stable(win.last))
  `MP2X2_ASSERT_NXT(a_emit_fills, clk, rst, emit, win.valid)

endmodule

`default_nettype wire

/* src/mp2x2_out.sv */
// Final window compare and output register of the pooling core.
// Depends on mp2x2_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mp2x2_out (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire mp2x2_pkg::win_t                      win,
  input  wire logic [mp2x2_pkg::PIX_W-1:0]          mem_rdata,
  output logic                                      out_ready,
  output logic                                      pooled_valid,
  input  wire logic                                 pooled_stall,
  output logic signed [mp2x2_pkg::PIX_W-1:0]        pooled_value,
  output logic                                      end_of_frame
);
  import mp2x2_pkg::*;

  assign out_ready = !pooled_valid || !pooled_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      pooled_valid <= 1'b0;
    end else if (out_ready) begin
      pooled_valid <= win.valid;
    end
    if (out_ready && win.valid) begin
      pooled_value <= max_s8(signed'(mem_rdata), win.pair);
      end_of_frame <= win.last;
    end
  end

endmodule

`default_nettype wire

/* src/max_pool_2x2_stream_core.sv */
// 2x2 stride-2 max pooling over a raster-order stream of signed 8-bit values.
// Channels: pixel_* carries one input value per item (valid/stall); pooled_*
// carries one window maximum per item with end_of_frame on the last window of
// a frame; cfg_* writes image_width (index 0) or image_height (index 1).
// Geometry values are clamped to 2..MAX_WIDTH / 2..MAX_HEIGHT on write and
// should only change while the block is idle.
// Rate: one pixel per cycle unless stalled; a pixel needs up to two compares and
// at most one access to the line store of pair maxima (MAX_WIDTH/2 entries).
// Window path: taking the window's last pixel loads the store read data and the
// window register; the final compare then writes the output register, which
// raises pooled_valid, as soon as that register is free to take it.
// Stall: a held result keeps its value; intake stops only when the output
// register and the window stage behind it are both full.
// Reset (synchronous): counters, held pixel and geometry (2 x 2) return to their
// reset values. The line store is not cleared; every entry is written by an
// even row before an odd row reads it.
// Depends on mp2x2_pkg, mp2x2_cfg, mp2x2_ctrl, mp2x2_ram, mp2x2_out.
`timescale 1ns / 1ps
`default_nettype none

module max_pool_2x2_stream_core #(
  parameter int MAX_WIDTH  = mp2x2_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = mp2x2_pkg::DEF_MAX_HEIGHT
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 cfg_valid,
  output logic                                      cfg_ready,
  input  wire logic [mp2x2_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  wire logic [mp2x2_pkg::CFG_W-1:0]          cfg_data,
  input  wire logic                                 pixel_valid,
  output logic                                      pixel_stall,
  input  wire logic signed [mp2x2_pkg::PIX_W-1:0]   pixel_value,
  output logic                                      pooled_valid,
  input  wire logic                                 pooled_stall,
  output logic signed [mp2x2_pkg::PIX_W-1:0]        pooled_value,
  output logic                                      end_of_frame
);
  import mp2x2_pkg::*;

  localparam int DW    = $clog2(MAX_WIDTH + 1);
  localparam int DH    = $clog2(MAX_HEIGHT + 1);
  localparam int CW    = $clog2(MAX_WIDTH);
  localparam int RW    = $clog2(MAX_HEIGHT);
  localparam int DEPTH = MAX_WIDTH / 2;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [DW-1:0]    width_eff;
  logic [DH-1:0]    height_eff;
  logic             out_ready;
  win_t             win;
  logic             mem_we;
  logic [AW-1:0]    mem_waddr;
  logic [PIX_W-1:0] mem_wdata;
  logic             mem_re;
  logic [AW-1:0]    mem_raddr;
  logic [PIX_W-1:0] mem_rdata;

  mp2x2_cfg #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .DW         (DW),
    .DH         (DH)
  ) u_cfg (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .width_eff  (width_eff),
    .height_eff (height_eff)
  );

  mp2x2_ctrl #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .DW         (DW),
    .DH         (DH),
    .CW         (CW),
    .RW         (RW),
    .AW         (AW)
  ) u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .width_eff   (width_eff),
    .height_eff  (height_eff),
    .pixel_valid (pixel_valid),
    .pixel_stall (pixel_stall),
    .pixel_value (pixel_value),
    .out_ready   (out_ready),
    .win         (win),
    .mem_we      (mem_we),
    .mem_waddr   (mem_waddr),
    .mem_wdata   (mem_wdata),
    .mem_re      (mem_re),
    .mem_raddr   (mem_raddr)
  );

  mp2x2_ram #(
    .WIDTH (PIX_W),
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_line_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  mp2x2_out u_out (
    .clk          (clk),
    .rst          (rst),
    .win          (win),
    .mem_rdata    (mem_rdata),
    .out_ready    (out_ready),
    .pooled_valid (pooled_valid),
    .pooled_stall (pooled_stall),
    .pooled_value (pooled_value),
    .end_of_frame (end_of_frame)
  );

endmodule

`default_nettype wire
